// ===== hdl/psopu_pkg.sv =====
// Package for the particle update block: word types, command struct,
// register indexes and reset values. No dependencies.
package psopu_pkg;

  localparam int NUM_CHANNELS = 2;

  localparam logic [1:0] OP_FIRST = 2'd0;
  localparam logic [1:0] OP_LATER = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_COGNITIVE_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOCIAL_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA_START  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA_FLOOR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INERTIA_SLOPE  = 3'd5;

  localparam logic [20:0]        RST_COGNITIVE_GAIN = 21'd131072;
  localparam logic [20:0]        RST_SOCIAL_GAIN    = 21'd131072;
  localparam logic [30:0]        RST_VELOCITY_LIMIT = 31'd65536;
  localparam logic [17:0]        RST_INERTIA_START  = 18'd58982;
  localparam logic signed [18:0] RST_INERTIA_FLOOR  = 19'sd26214;
  localparam logic signed [17:0] RST_INERTIA_SLOPE  = -18'sd655;
  localparam logic signed [31:0] RST_INERTIA        = 32'sd58982;

  typedef struct packed {
    logic [1:0]         op;
    logic               channel;
    logic signed [31:0] u_now;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] personal_best;
    logic signed [31:0] global_best;
    logic [16:0]        rand_one;
    logic [16:0]        rand_two;
    logic [30:0]        step_limit;
    logic signed [31:0] upper_bound;
    logic signed [31:0] lower_bound;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_position;
    logic signed [31:0] new_velocity;
  } out_word_t;

  typedef struct packed {
    logic [20:0]        cognitive_gain;
    logic [20:0]        social_gain;
    logic [30:0]        velocity_limit;
    logic [17:0]        inertia_start;
    logic signed [18:0] inertia_floor;
    logic signed [17:0] inertia_slope;
  } cfg_regs_t;

  typedef struct packed {
    logic load;
    logic inertia_step;
    logic mul1;
    logic mul2;
    logic mul3;
    logic vsum;
    logic limit;
    logic finish;
  } dp_cmd_t;

endpackage

// ===== hdl/psopu_regs.sv =====
// Configuration register bank of the particle update block.
// Depends on psopu_pkg.
module psopu_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [psopu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psopu_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output psopu_pkg::cfg_regs_t                cfg
);

  psopu_pkg::cfg_regs_t regs_r, regs_nxt;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        psopu_pkg::REG_COGNITIVE_GAIN: regs_nxt.cognitive_gain = cfg_wdata[20:0];
        psopu_pkg::REG_SOCIAL_GAIN:    regs_nxt.social_gain    = cfg_wdata[20:0];
        psopu_pkg::REG_VELOCITY_LIMIT: regs_nxt.velocity_limit = cfg_wdata[30:0];
        psopu_pkg::REG_INERTIA_START:  regs_nxt.inertia_start  = cfg_wdata[17:0];
        psopu_pkg::REG_INERTIA_FLOOR:  regs_nxt.inertia_floor  = cfg_wdata[18:0];
        psopu_pkg::REG_INERTIA_SLOPE:  regs_nxt.inertia_slope  = cfg_wdata[17:0];
        default:                       regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.cognitive_gain <= psopu_pkg::RST_COGNITIVE_GAIN;
      regs_r.social_gain    <= psopu_pkg::RST_SOCIAL_GAIN;
      regs_r.velocity_limit <= psopu_pkg::RST_VELOCITY_LIMIT;
      regs_r.inertia_start  <= psopu_pkg::RST_INERTIA_START;
      regs_r.inertia_floor  <= psopu_pkg::RST_INERTIA_FLOOR;
      regs_r.inertia_slope  <= psopu_pkg::RST_INERTIA_SLOPE;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign cfg = regs_r;

endmodule

// ===== hdl/psopu_dp.sv =====
// Datapath of the particle update block: two shared multipliers, the velocity
// and position limit stages, the inertia weight and the per-channel history.
// Depends on psopu_pkg.
module psopu_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  psopu_pkg::dp_cmd_t    cmd,
  input  psopu_pkg::cfg_regs_t  cfg,
  input  psopu_pkg::in_word_t   in_word,
  output psopu_pkg::out_word_t  out_word
);

  logic signed [31:0] u_now_r, x_r, v_r, hi_r, lo_r;
  logic [16:0]        r1_r, r2_r;
  logic [30:0]        du_r;
  logic               first_r;
  logic               ch_r;
  logic signed [32:0] d1_r, d2_r;

  logic signed [31:0] inertia_r;
  logic signed [31:0] prev_r [psopu_pkg::NUM_CHANNELS];

  logic signed [22:0] a_op1;
  logic signed [32:0] a_op2;
  logic signed [55:0] a_prod, pa_r;
  logic signed [31:0] b_op1, b_op2;
  logic signed [63:0] b_prod, pb_r;
  logic [21:0]        g2_r;
  logic signed [48:0] acc_r;

  logic signed [49:0] vsum, vlim_s;
  logic signed [31:0] vn, vn_r;

  logic signed [31:0] anchor;
  logic signed [32:0] xn, a_plus, a_minus, xl, xl_r;
  logic signed [33:0] dx, du_s;
  logic signed [32:0] hi_s, lo_s;
  logic signed [31:0] xc;
  psopu_pkg::out_word_t out_r;

  logic signed [32:0] wt, wf_s;
  logic signed [31:0] w_nxt;

  always_comb begin
    if (cmd.mul1) begin
      a_op1 = {2'b00, cfg.cognitive_gain};
      a_op2 = {16'b0, r1_r};
      b_op1 = {11'b0, cfg.social_gain};
      b_op2 = {15'b0, r2_r};
    end else if (cmd.mul2) begin
      a_op1 = {1'b0, pa_r[37:16]};
      a_op2 = d1_r;
      b_op1 = inertia_r;
      b_op2 = v_r;
    end else begin
      a_op1 = {1'b0, g2_r};
      a_op2 = d2_r;
      b_op1 = inertia_r;
      b_op2 = v_r;
    end
  end

  assign a_prod = a_op1 * a_op2;
  assign b_prod = b_op1 * b_op2;

  assign vsum   = 50'(acc_r) + 50'($signed(pa_r[55:16]));
  assign vlim_s = {19'b0, cfg.velocity_limit};

  always_comb begin
    if (vsum > vlim_s) begin
      vn = {1'b0, cfg.velocity_limit};
    end else if (vsum < -vlim_s) begin
      vn = -$signed({1'b0, cfg.velocity_limit});
    end else begin
      vn = vsum[31:0];
    end
  end

  assign anchor  = first_r ? u_now_r : prev_r[ch_r];
  assign xn      = 33'(x_r) + 33'(vn_r);
  assign dx      = 34'(xn) - 34'(anchor);
  assign du_s    = {3'b0, du_r};
  assign a_plus  = 33'(anchor) + $signed({2'b0, du_r});
  assign a_minus = 33'(anchor) - $signed({2'b0, du_r});

  always_comb begin
    if (dx > du_s) begin
      xl = a_plus;
    end else if (dx < -du_s) begin
      xl = a_minus;
    end else begin
      xl = xn;
    end
  end

  assign hi_s = 33'(hi_r);
  assign lo_s = 33'(lo_r);

  always_comb begin
    if (xl_r > hi_s) begin
      xc = hi_r;
    end else if (xl_r < lo_s) begin
      xc = lo_r;
    end else begin
      xc = xl_r[31:0];
    end
  end

  assign wt   = 33'(inertia_r) + 33'(cfg.inertia_slope);
  assign wf_s = 33'(cfg.inertia_floor);

  always_comb begin
    if (wt <= wf_s) begin
      w_nxt = {14'b0, cfg.inertia_start};
    end else if (wt > 33'sh0_7FFF_FFFF) begin
      w_nxt = 32'sh7FFF_FFFF;
    end else if (wt < -33'sh0_8000_0000) begin
      w_nxt = 32'sh8000_0000;
    end else begin
      w_nxt = wt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r <= psopu_pkg::RST_INERTIA;
    end else if (cmd.inertia_step) begin
      inertia_r <= w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u_now_r <= in_word.u_now;
      x_r     <= in_word.position;
      v_r     <= in_word.velocity;
      hi_r    <= in_word.upper_bound;
      lo_r    <= in_word.lower_bound;
      r1_r    <= in_word.rand_one;
      r2_r    <= in_word.rand_two;
      du_r    <= in_word.step_limit;
      first_r <= (in_word.op == psopu_pkg::OP_FIRST);
      ch_r    <= in_word.channel;
      d1_r    <= 33'($signed(in_word.personal_best)) - 33'($signed(in_word.position));
      d2_r    <= 33'($signed(in_word.global_best)) - 33'($signed(in_word.position));
    end
    if (cmd.mul1 || cmd.mul2 || cmd.mul3) begin
      pa_r <= a_prod;
    end
    if (cmd.mul1 || cmd.mul2) begin
      pb_r <= b_prod;
    end
    if (cmd.mul2) begin
      g2_r <= pb_r[37:16];
    end
    if (cmd.mul3) begin
      acc_r <= 49'($signed(pa_r[55:16])) + 49'($signed(pb_r[63:16]));
    end
    if (cmd.vsum) begin
      vn_r <= vn;
    end
    if (cmd.limit) begin
      xl_r <= xl;
    end
    if (cmd.finish) begin
      out_r.new_position <= xc;
      out_r.new_velocity <= vn_r;
      prev_r[ch_r]       <= xc;
    end
  end

  assign out_word = out_r;

endmodule

// ===== hdl/psopu_ctrl.sv =====
// Controller of the particle update block: accepts words, sequences the
// datapath stages and holds the result valid flag. Depends on psopu_pkg.
module psopu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               in_channel,
  input  logic               out_stall,
  output logic               in_stall,
  output logic               out_valid,
  output psopu_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL1  = 3'd1;
  localparam logic [2:0] ST_MUL2  = 3'd2;
  localparam logic [2:0] ST_MUL3  = 3'd3;
  localparam logic [2:0] ST_VSUM  = 3'd4;
  localparam logic [2:0] ST_LIMIT = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept, is_element;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_element = ((in_op == psopu_pkg::OP_FIRST) || (in_op == psopu_pkg::OP_LATER))
                      && (32'(in_channel) < psopu_pkg::NUM_CHANNELS);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == psopu_pkg::OP_END) begin
            cmd.inertia_step = 1'b1;
          end else if (is_element) begin
            cmd.load  = 1'b1;
            state_nxt = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul3  = 1'b1;
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        cmd.vsum  = 1'b1;
        state_nxt = ST_LIMIT;
      end
      ST_LIMIT: begin
        cmd.limit = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.finish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("datapath commands overlap");

  a_element_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_element |=> state_r == ST_MUL1)
    else $error("accepted element did not start the multiply sequence");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && !out_stall |=> out_valid && state_r == ST_IDLE)
    else $error("finished element did not reach the output register");

  a_end_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_op == psopu_pkg::OP_END && !out_valid |=> !out_valid)
    else $error("end of iteration word produced a result");

endmodule

// ===== hdl/pso_particle_update_rate_limited.sv =====
// Particle swarm update for one particle element per word, top level. An element word
// (op 0 or 1) gives one result after three rounds through the two shared multipliers and the
// serial add, rate limit and range clamp stages; the next word is accepted in the cycle after
// that result is loaded, so no new word is taken while an element is in flight. An
// end-of-iteration word (op 2) updates the inertia weight in the cycle it is accepted and
// gives no result; op 3 is dropped. A result waiting on out_stall does not block acceptance
// of the next word. Configuration is written through cfg_we, cfg_index and cfg_wdata while
// the block is idle; the user must keep to that, the block does not enforce it. Needs psopu_pkg.
module pso_particle_update_rate_limited (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  psopu_pkg::in_word_t              in_word,
  output logic                             out_valid,
  input  logic                             out_stall,
  output psopu_pkg::out_word_t             out_word,
  input  logic                             cfg_we,
  input  logic [psopu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psopu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  psopu_pkg::cfg_regs_t cfg;
  psopu_pkg::dp_cmd_t   cmd;

  psopu_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  psopu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_op      (in_word.op),
    .in_channel (in_word.channel),
    .out_stall  (out_stall),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .cmd        (cmd)
  );

  psopu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule

// ===== bench/psopu_update_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the particle update block: watches the word and register channels,
// predicts each result word from its own copy of the inertia, gains and channel history,
// and counts mismatches. Depends on psopu_pkg.
module psopu_update_checker
  import psopu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_word_t              in_word,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    errors,
  output int                    outstanding
);

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  longint    c1_gain;
  longint    c2_gain;
  longint    v_max;
  longint    w_start;
  longint    w_floor;
  longint    w_slope;
  longint    inertia;
  longint    last_position [NUM_CHANNELS];
  out_word_t pending_updates [$];

  function automatic out_word_t predict_update(in_word_t w);
    longint    x;
    longint    t0;
    longint    g1;
    longint    g2;
    longint    vn;
    longint    anchor;
    longint    xn;
    longint    du;
    longint    hi;
    longint    lo;
    out_word_t r;
    x  = longint'($signed(w.position));
    t0 = (inertia * longint'($signed(w.velocity))) >>> 16;
    g1 = (c1_gain * longint'(w.rand_one)) >>> 16;
    g2 = (c2_gain * longint'(w.rand_two)) >>> 16;
    g1 = (g1 * (longint'($signed(w.personal_best)) - x)) >>> 16;
    g2 = (g2 * (longint'($signed(w.global_best)) - x)) >>> 16;
    vn = t0 + g1 + g2;
    if (vn > v_max) vn = v_max;
    else if (vn < -v_max) vn = -v_max;
    if (w.op == OP_FIRST) anchor = longint'($signed(w.u_now));
    else anchor = last_position[w.channel];
    du = longint'(w.step_limit);
    xn = x + vn;
    if (xn - anchor > du) xn = anchor + du;
    else if (xn - anchor < -du) xn = anchor - du;
    hi = longint'($signed(w.upper_bound));
    lo = longint'($signed(w.lower_bound));
    if (xn > hi) xn = hi;
    else if (xn < lo) xn = lo;
    last_position[w.channel] = xn;
    r.new_position = xn[31:0];
    r.new_velocity = vn[31:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    longint    wt;
    if (!rst_n) begin
      c1_gain = longint'(RST_COGNITIVE_GAIN);
      c2_gain = longint'(RST_SOCIAL_GAIN);
      v_max   = longint'(RST_VELOCITY_LIMIT);
      w_start = longint'(RST_INERTIA_START);
      w_floor = longint'(RST_INERTIA_FLOOR);
      w_slope = longint'(RST_INERTIA_SLOPE);
      inertia = longint'(RST_INERTIA);
      foreach (last_position[i]) last_position[i] = 0;
      pending_updates.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COGNITIVE_GAIN: c1_gain = longint'(cfg_wdata[20:0]);
          REG_SOCIAL_GAIN:    c2_gain = longint'(cfg_wdata[20:0]);
          REG_VELOCITY_LIMIT: v_max   = longint'(cfg_wdata[30:0]);
          REG_INERTIA_START:  w_start = longint'(cfg_wdata[17:0]);
          REG_INERTIA_FLOOR:  w_floor = longint'($signed(cfg_wdata[18:0]));
          REG_INERTIA_SLOPE:  w_slope = longint'($signed(cfg_wdata[17:0]));
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_updates.size() == 0) begin
          $error("result word %h arrived with none expected", out_word);
          errors++;
        end else begin
          want = pending_updates.pop_front();
          if (out_word.new_position !== want.new_position) begin
            $error("new_position expected %0d got %0d", want.new_position,
                   out_word.new_position);
            errors++;
          end
          if (out_word.new_velocity !== want.new_velocity) begin
            $error("new_velocity expected %0d got %0d", want.new_velocity,
                   out_word.new_velocity);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        case (in_word.op)
          OP_FIRST, OP_LATER: pending_updates.push_back(predict_update(in_word));
          OP_END: begin
            wt = inertia + w_slope;
            if (wt <= w_floor) inertia = w_start;
            else if (wt > Q_MAX) inertia = Q_MAX;
            else if (wt < Q_MIN) inertia = Q_MIN;
            else inertia = wt;
          end
          default: ;
        endcase
      end
    end
    outstanding = pending_updates.size();
  end

endmodule

// ===== bench/tb_pso_particle_update_rate_limited.sv =====
`timescale 1ns / 100ps
// Top of the particle update bench: clock, reset, word stimulus with random idling and two
// long receiver hold-offs, and register phases between drained runs. Depends on psopu_pkg,
// psopu_update_checker and the block itself.
module tb_pso_particle_update_rate_limited;
  import psopu_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [31:0] Q_HI      = 32'h7fff_ffff;
  localparam logic [31:0] Q_LO      = 32'h8000_0000;
  localparam logic [30:0] DU_TOP    = 31'h7fff_ffff;
  localparam logic [16:0] R_UNIT    = 17'd65536;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  in_word_t                in_word;
  logic                    out_valid;
  logic                    out_stall;
  out_word_t               out_word;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  int                      fail_count;
  int                      outstanding;
  int                      words_sent = 0;
  logic                    calm;
  logic [NUM_CHANNELS-1:0] written = '0;

  assign calm = (words_sent >= 600) && (words_sent < 800);

  pso_particle_update_rate_limited i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  psopu_update_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .errors      (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[pso_particle_update_rate_limited] ERROR");
    $finish;
  end

  // The receiver holds off twice for a long stretch so that the block backs up.
  initial begin : receiver
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && holds_done < 2 && words_sent >= 350 + holds_done * 650) begin
        hold_left = 200;
        holds_done++;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 33);
      end
    end
  end

  function automatic in_word_t mk(logic [1:0] op, logic ch, logic [31:0] u, x, v, pb, gb,
                                  logic [16:0] r1, r2, logic [30:0] du, logic [31:0] hi, lo);
    in_word_t w;
    w.op            = op;
    w.channel       = ch;
    w.u_now         = u;
    w.position      = x;
    w.velocity      = v;
    w.personal_best = pb;
    w.global_best   = gb;
    w.rand_one      = r1;
    w.rand_two      = r2;
    w.step_limit    = du;
    w.upper_bound   = hi;
    w.lower_bound   = lo;
    return w;
  endfunction

  function automatic int spread(int centre, int span);
    return centre + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int pick_range(int lo, int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [16:0] pick_rand();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return R_UNIT;
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic in_word_t elem(logic [1:0] op, logic ch);
    in_word_t w;
    int       x;
    int       gap;
    w.op      = op;
    w.channel = ch;
    if ($urandom_range(0, 9) < 7) begin
      x                = spread(0, 1 << 22);
      w.position       = x;
      w.velocity       = spread(0, 1 << 18);
      w.personal_best  = spread(x, 1 << 18);
      w.global_best    = spread(x, 1 << 20);
      w.u_now          = spread(x, 1 << 18);
    end else begin
      w.position       = $urandom;
      w.velocity       = $urandom;
      w.personal_best  = $urandom;
      w.global_best    = $urandom;
      w.u_now          = $urandom;
    end
    x = w.position;
    w.rand_one = pick_rand();
    w.rand_two = pick_rand();
    case ($urandom_range(0, 9))
      0:          w.step_limit = 31'd0;
      1:          w.step_limit = DU_TOP;
      2, 3, 4, 5: w.step_limit = 31'($urandom_range(0, 1 << 18));
      default:    w.step_limit = 31'($urandom);
    endcase
    gap = int'($urandom_range(0, 1 << 20));
    case ($urandom_range(0, 9))
      0: begin
        w.upper_bound = Q_HI;
        w.lower_bound = Q_LO;
      end
      1: begin
        w.upper_bound = $urandom;
        w.lower_bound = $urandom;
      end
      2: begin
        w.upper_bound = x - gap;
        w.lower_bound = x + gap + 1;
      end
      default: begin
        w.upper_bound = x + gap;
        w.lower_bound = x - int'($urandom_range(0, 1 << 20));
      end
    endcase
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    if (w.op == OP_FIRST || w.op == OP_LATER) written[w.channel] = 1'b1;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_config(int c1, int c2, int vl, int w0, int wf, int ws);
    write_reg(REG_COGNITIVE_GAIN, 31'(c1));
    write_reg(REG_SOCIAL_GAIN, 31'(c2));
    write_reg(REG_VELOCITY_LIMIT, 31'(vl));
    write_reg(REG_INERTIA_START, 31'(w0));
    write_reg(REG_INERTIA_FLOOR, 31'(wf));
    write_reg(REG_INERTIA_SLOPE, 31'(ws));
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    int c1;
    int c2;
    int vl;
    c1 = ($urandom_range(0, 1)) ? pick_range(0, 1 << 20) : int'($urandom_range(0, 1 << 18));
    c2 = ($urandom_range(0, 1)) ? pick_range(0, 1 << 20) : int'($urandom_range(0, 1 << 18));
    vl = ($urandom_range(0, 1)) ? pick_range(0, 32'h7fff_ffff)
                                : int'($urandom_range(1 << 14, 1 << 22));
    load_config(c1, c2, vl, pick_range(0, 131072), pick_range(-131072, 131072),
                pick_range(-65536, 65536));
  endtask

  task automatic run_traffic(int count);
    int       sent;
    int       h;
    int       s;
    int       c;
    in_word_t w;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 85) begin
        h = $urandom_range(1, 4);
        for (s = 0; s < h; s++) begin
          for (c = 0; c < NUM_CHANNELS; c++) begin
            send_word(elem((s == 0) ? OP_FIRST : OP_LATER, 1'(c)));
            sent++;
          end
        end
        w    = elem(OP_END, 1'($urandom_range(0, 1)));
        send_word(w);
        sent++;
      end else begin
        c = $urandom_range(0, 1);
        case ($urandom_range(0, 3))
          0: w = elem(OP_FIRST, 1'(c));
          1: w = elem(written[c] ? OP_LATER : OP_FIRST, 1'(c));
          2: w = elem(OP_END, 1'(c));
          default: w = elem(OP_UNUSED, 1'(c));
        endcase
        send_word(w);
        if (w.op != OP_UNUSED) sent++;
      end
    end
  endtask

  initial begin : stimulus
    int p;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_word   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_word(mk(OP_FIRST, 1'b0, 32'sd0, 32'sh10000, 32'sh8000, 32'sh20000, 32'sh30000,
                 17'h8000, 17'h4000, 31'h10000, 32'sh100000, -32'sh100000));
    send_word(mk(OP_LATER, 1'b0, 32'sd0, 32'sh400000, 32'sh8000, 32'sh500000, 32'sh600000,
                 17'h8000, 17'h8000, 31'h100, Q_HI, Q_LO));
    send_word(mk(OP_LATER, 1'b0, 32'sd0, -32'sh400000, -32'sh8000, -32'sh500000,
                 -32'sh600000, 17'h8000, 17'h8000, 31'h100, Q_HI, Q_LO));
    send_word(mk(OP_FIRST, 1'b1, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, R_UNIT, R_UNIT, DU_TOP,
                 Q_HI, Q_LO));
    send_word(mk(OP_FIRST, 1'b1, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, 17'd0, 17'd0, 31'd0,
                 Q_HI, Q_LO));
    send_word(mk(OP_FIRST, 1'b0, 32'sd0, Q_HI, 32'sd0, Q_LO, Q_LO, R_UNIT, R_UNIT, DU_TOP,
                 Q_HI, Q_LO));
    send_word(mk(OP_FIRST, 1'b0, 32'sd0, Q_LO, 32'sd0, Q_HI, Q_HI, R_UNIT, R_UNIT, DU_TOP,
                 Q_HI, Q_LO));
    // Lower bound above upper bound, value above the upper one and then below both.
    send_word(mk(OP_LATER, 1'b1, 32'sd0, 32'sh50000, 32'sd0, 32'sh50000, 32'sh50000,
                 17'd0, 17'd0, DU_TOP, -32'sh10000, 32'sh10000));
    send_word(mk(OP_LATER, 1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'd0, 17'd0,
                 DU_TOP, 32'sh10000, 32'sh20000));
    send_word(mk(OP_LATER, 1'b0, 32'sd0, 32'sh30000, 32'sh10000, 32'sh40000, 32'sh40000,
                 17'h1000, 17'h1000, 31'd0, 32'sh8000, -32'sh8000));
    send_word(mk(OP_END, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'd0, 17'd0,
                 31'd0, 32'sd0, 32'sd0));
    send_word(mk(OP_UNUSED, 1'b0, Q_HI, Q_HI, Q_HI, Q_HI, Q_HI, R_UNIT, R_UNIT, DU_TOP,
                 Q_HI, Q_LO));
    send_word(mk(OP_END, 1'b1, Q_LO, Q_LO, Q_LO, Q_LO, Q_LO, R_UNIT, R_UNIT, DU_TOP,
                 Q_LO, Q_HI));
    send_word(mk(OP_FIRST, 1'b0, Q_LO, Q_HI, Q_LO, Q_HI, Q_LO, 17'h5555, 17'haaaa, DU_TOP,
                 Q_HI, Q_LO));
    send_word(mk(OP_LATER, 1'b1, 32'sd0, 32'sh12345, 32'sh6789, 32'sh1000, 32'sh2000,
                 17'hffff, 17'h10000, 31'h55555555, 32'sd0, 32'sd0));
    send_word(mk(OP_FIRST, 1'b1, 32'sd0, 32'sh70000, 32'sd0, 32'sh70000, 32'sh70000,
                 17'd0, 17'd0, 31'h2aaaaaaa, Q_LO, Q_LO));
    send_word(mk(OP_FIRST, 1'b0, 32'sh20000, 32'sh20000, 32'sd0, 32'sh20000, 32'sh20000,
                 R_UNIT, R_UNIT, 31'h10000, 32'sh100000, -32'sh100000));
    send_word(mk(OP_END, 1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 17'd0, 17'd0,
                 31'd0, 32'sd0, 32'sd0));
    send_word(mk(OP_LATER, 1'b0, 32'sd0, -32'sh20000, 32'sh40000, 32'sh10000, -32'sh10000,
                 17'h8000, 17'h8000, 31'h8000, 32'sh100000, -32'sh100000));
    settle();

    load_config(1 << 20, 1 << 20, 32'h7fff_ffff, 131072, 131072, 65536);
    run_traffic(90);
    settle();
    load_config(0, 0, 0, 0, -131072, -65536);
    run_traffic(90);
    settle();
    for (p = 0; p < 10; p++) begin
      random_config();
      run_traffic(130);
      settle();
    end

    if (fail_count == 0) $display("[pso_particle_update_rate_limited] OK");
    else $display("[pso_particle_update_rate_limited] ERROR");
    $finish;
  end

endmodule
